// File: src/tcbp_pkg.sv
// ============================================================================
// Teleop command byte parser package
// Shared types and constants for the front end, the queue and the back end.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package tcbp_pkg;

    // Event reported on the result channel.
    typedef enum logic [1:0] {
        EV_APPLIED  = 2'd0,
        EV_REJECTED = 2'd1,
        EV_TIMEOUT  = 2'd2
    } event_kind_t;

    // Command carried by a header byte.
    typedef enum logic [1:0] {
        CMD_STEER = 2'd0,
        CMD_ACCEL = 2'd1,
        CMD_DIR   = 2'd2,
        CMD_BRAKE = 2'd3
    } cmd_kind_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_STEERING_CODE   = 3'd0;
    localparam logic [2:0] CFG_ACCEL_CODE      = 3'd1;
    localparam logic [2:0] CFG_DIRECTION_CODE  = 3'd2;
    localparam logic [2:0] CFG_BRAKE_CODE      = 3'd3;
    localparam logic [2:0] CFG_STEERING_LIMIT  = 3'd4;
    localparam logic [2:0] CFG_ACCEL_LIMIT     = 3'd5;
    localparam logic [2:0] CFG_BYTE_WAIT_TICKS = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [7:0]  RST_STEERING_CODE   = 8'd1;
    localparam logic [7:0]  RST_ACCEL_CODE      = 8'd2;
    localparam logic [7:0]  RST_DIRECTION_CODE  = 8'd3;
    localparam logic [7:0]  RST_BRAKE_CODE      = 8'd4;
    localparam logic [15:0] RST_STEERING_LIMIT  = 16'hFFFF;
    localparam logic [15:0] RST_ACCEL_LIMIT     = 16'hFFFF;
    localparam logic [15:0] RST_BYTE_WAIT_TICKS = 16'd1000;

    // Header codes, used by the front end.
    typedef struct packed {
        logic [7:0] steering_code;
        logic [7:0] accel_code;
        logic [7:0] direction_code;
        logic [7:0] brake_code;
    } tcbp_codes_t;

    // Limits and timeout, used by the back end.
    typedef struct packed {
        logic [15:0] steering_limit;
        logic [15:0] accel_limit;
        logic [15:0] byte_wait_ticks;
    } tcbp_limits_t;

    // A classified input beat as it travels through the queue.
    typedef struct packed {
        logic       is_tick;
        logic       hdr_hit;
        cmd_kind_t  hdr_kind;
        logic [7:0] rx_byte;
    } tcbp_item_t;

    // One result beat.
    typedef struct packed {
        event_kind_t event_kind;
        cmd_kind_t   command_kind;
        logic [15:0] setpoint_value;
        logic        was_clamped;
        logic        watchdog_kick;
    } tcbp_result_t;

endpackage

`default_nettype wire

// File: src/tcbp_front.sv
// ============================================================================
// Teleop command byte parser front end
// Accepts input beats and tags each byte with the header code it matches.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tcbp_front (
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,
    input  wire logic                 s_tuser,
    input  wire tcbp_pkg::tcbp_codes_t codes,
    input  wire logic                 q_full,
    output logic                      q_push,
    output tcbp_pkg::tcbp_item_t      q_item
);
    import tcbp_pkg::*;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // When several codes are equal the earlier command in this chain wins.
    always_comb begin
        q_item.is_tick  = s_tuser;
        q_item.rx_byte  = s_tdata;
        q_item.hdr_hit  = 1'b1;
        q_item.hdr_kind = CMD_STEER;
        priority if (s_tdata == codes.steering_code) begin
            q_item.hdr_kind = CMD_STEER;
        end else if (s_tdata == codes.accel_code) begin
            q_item.hdr_kind = CMD_ACCEL;
        end else if (s_tdata == codes.direction_code) begin
            q_item.hdr_kind = CMD_DIR;
        end else if (s_tdata == codes.brake_code) begin
            q_item.hdr_kind = CMD_BRAKE;
        end else begin
            q_item.hdr_hit  = 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: src/tcbp_queue.sv
// ============================================================================
// Teleop command byte parser queue
// Small register queue of classified beats between front and back end.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tcbp_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire tcbp_pkg::tcbp_item_t push_item,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      pop_valid,
    output tcbp_pkg::tcbp_item_t      pop_item
);
    import tcbp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tcbp_item_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: src/tcbp_back.sv
// ============================================================================
// Teleop command byte parser back end
// Runs the command state machine and holds the result output register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tcbp_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire tcbp_pkg::tcbp_limits_t limits,
    input  wire logic                  q_valid,
    input  wire tcbp_pkg::tcbp_item_t  q_item,
    output logic                       q_pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output tcbp_pkg::tcbp_result_t     m_result
);
    import tcbp_pkg::*;

    typedef enum logic [6:0] {
        PH_HUNT     = 7'b0000001,
        PH_STEER_LO = 7'b0000010,
        PH_STEER_HI = 7'b0000100,
        PH_ACCEL_LO = 7'b0001000,
        PH_ACCEL_HI = 7'b0010000,
        PH_DIR      = 7'b0100000,
        PH_BRAKE    = 7'b1000000
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [7:0]   low_half_reg, low_half_next;
    logic [15:0]  wait_count_reg, wait_count_next;
    logic         m_valid_reg;
    tcbp_result_t result_reg;

    logic         back_ready;
    logic         res_fire;
    tcbp_result_t res;
    logic         busy;
    cmd_kind_t    phase_cmd;
    logic [16:0]  wait_inc;
    logic [15:0]  joined;
    logic [15:0]  limit_sel;

    assign back_ready = !m_valid_reg || m_ready;
    assign q_pop      = q_valid && back_ready;
    assign m_valid    = m_valid_reg;
    assign m_result   = result_reg;

    assign wait_inc  = {1'b0, wait_count_reg} + 17'd1;
    assign joined    = {q_item.rx_byte, low_half_reg};
    assign limit_sel = (phase_reg == PH_STEER_HI) ? limits.steering_limit
                                                  : limits.accel_limit;

    always_comb begin
        busy      = 1'b1;
        phase_cmd = CMD_BRAKE;
        unique case (phase_reg)
            PH_STEER_LO, PH_STEER_HI: phase_cmd = CMD_STEER;
            PH_ACCEL_LO, PH_ACCEL_HI: phase_cmd = CMD_ACCEL;
            PH_DIR:                   phase_cmd = CMD_DIR;
            PH_BRAKE:                 phase_cmd = CMD_BRAKE;
            default:                  busy      = 1'b0;
        endcase
    end

    always_comb begin
        phase_next      = phase_reg;
        low_half_next   = low_half_reg;
        wait_count_next = wait_count_reg;
        res_fire        = 1'b0;
        res.event_kind     = EV_APPLIED;
        res.command_kind   = phase_cmd;
        res.setpoint_value = {8'd0, q_item.rx_byte};
        res.was_clamped    = 1'b0;
        res.watchdog_kick  = 1'b0;

        if (q_pop) begin
            if (!busy) begin
                // Hunting: ticks are ignored, bytes are matched against the headers.
                phase_next = PH_HUNT;
                if (!q_item.is_tick) begin
                    wait_count_next = '0;
                    if (q_item.hdr_hit) begin
                        unique case (q_item.hdr_kind)
                            CMD_STEER: phase_next = PH_STEER_LO;
                            CMD_ACCEL: phase_next = PH_ACCEL_LO;
                            CMD_DIR:   phase_next = PH_DIR;
                            default:   phase_next = PH_BRAKE;
                        endcase
                    end
                end
            end else if (q_item.is_tick) begin
                if (wait_inc >= {1'b0, limits.byte_wait_ticks}) begin
                    res_fire           = 1'b1;
                    res.event_kind     = EV_TIMEOUT;
                    res.setpoint_value = '0;
                    phase_next         = PH_HUNT;
                    wait_count_next    = '0;
                end else begin
                    wait_count_next = wait_inc[15:0];
                end
            end else begin
                wait_count_next = '0;
                unique case (phase_reg)
                    PH_STEER_LO, PH_ACCEL_LO: begin
                        low_half_next = q_item.rx_byte;
                        phase_next    = (phase_reg == PH_STEER_LO) ? PH_STEER_HI
                                                                   : PH_ACCEL_HI;
                    end
                    PH_STEER_HI, PH_ACCEL_HI: begin
                        res_fire          = 1'b1;
                        res.watchdog_kick = 1'b1;
                        if (joined > limit_sel) begin
                            res.setpoint_value = limit_sel;
                            res.was_clamped    = 1'b1;
                        end else begin
                            res.setpoint_value = joined;
                        end
                        phase_next = PH_HUNT;
                    end
                    default: begin
                        // Direction and brake take a single byte; 0 or 1 applies, others are rejected.
                        res_fire = 1'b1;
                        if (q_item.rx_byte <= 8'd1) begin
                            res.watchdog_kick = 1'b1;
                        end else begin
                            res.event_kind = EV_REJECTED;
                        end
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT;
            wait_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            wait_count_reg <= wait_count_next;
            if (back_ready) begin
                m_valid_reg <= res_fire;
            end
        end
    end

    always_ff @(posedge aclk) begin
        low_half_reg <= low_half_next;
        if (back_ready && res_fire) begin
            result_reg <= res;
        end
    end

endmodule

`default_nettype wire

// File: src/teleop_command_byte_parser.sv
// ============================================================================
// Teleop command byte parser
// Parses header-led steering, acceleration, direction and brake commands.
// ============================================================================
//
//  Channel   Direction  Beat contents
//  --------  ---------  -------------------------------------------------
//  s_        in         tdata: received byte; tuser: 1 = 10 us tick
//  m_        out        tdata: setpoint, clamp flag, watchdog kick;
//                       tuser: event kind, command kind
//  cfg_      in         write enable, register index, write data
//
// One input beat is accepted per clock while the queue is not full. A beat
// is classified against the header codes on acceptance and written into a
// two-entry queue; the back end takes one queued beat per clock unless the
// output stalls, and a result passes through the queue and the output
// register before it shows on m_tvalid. The output register is refilled in
// the same cycle that its beat is taken. A stalled output holds the back
// end, the queue fills, and s_tready drops only when the queue is full.
// Reset is synchronous and active low; it returns the parser to header hunt
// and all configuration registers to their default values.
// Configuration writes take effect on the next clock edge.
//
`timescale 1ns / 1ps
`default_nettype none

module teleop_command_byte_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] rx_byte
    input  wire logic        s_tuser,     // [0] mode

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,     // [15:0] setpoint_value, [16] was_clamped,
                                          // [17] watchdog_kick, [23:18] zero
    output logic [3:0]       m_tuser,     // [1:0] event_kind, [3:2] command_kind

    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);
    import tcbp_pkg::*;

    // Configuration registers.
    tcbp_codes_t  codes_reg;
    tcbp_limits_t limits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codes_reg.steering_code    <= RST_STEERING_CODE;
            codes_reg.accel_code       <= RST_ACCEL_CODE;
            codes_reg.direction_code   <= RST_DIRECTION_CODE;
            codes_reg.brake_code       <= RST_BRAKE_CODE;
            limits_reg.steering_limit  <= RST_STEERING_LIMIT;
            limits_reg.accel_limit     <= RST_ACCEL_LIMIT;
            limits_reg.byte_wait_ticks <= RST_BYTE_WAIT_TICKS;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_STEERING_CODE:   codes_reg.steering_code    <= cfg_wdata[7:0];
                CFG_ACCEL_CODE:      codes_reg.accel_code       <= cfg_wdata[7:0];
                CFG_DIRECTION_CODE:  codes_reg.direction_code   <= cfg_wdata[7:0];
                CFG_BRAKE_CODE:      codes_reg.brake_code       <= cfg_wdata[7:0];
                CFG_STEERING_LIMIT:  limits_reg.steering_limit  <= cfg_wdata;
                CFG_ACCEL_LIMIT:     limits_reg.accel_limit     <= cfg_wdata;
                CFG_BYTE_WAIT_TICKS: limits_reg.byte_wait_ticks <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Front end: accept and classify.
    logic         q_full;
    logic         q_push;
    tcbp_item_t   q_in_item;

    tcbp_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .codes    (codes_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in_item)
    );

    // Queue between the two halves.
    logic         q_pop;
    logic         q_valid;
    tcbp_item_t   q_out_item;

    tcbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_out_item)
    );

    // Back end: command state machine and output register.
    tcbp_result_t m_result;

    tcbp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .limits   (limits_reg),
        .q_valid  (q_valid),
        .q_item   (q_out_item),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {6'd0, m_result.watchdog_kick, m_result.was_clamped,
                      m_result.setpoint_value};
    assign m_tuser = {m_result.command_kind, m_result.event_kind};

    // A watchdog kick goes with an applied command and with nothing else.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[17] == (m_tuser[1:0] == EV_APPLIED)))
        else $error("watchdog kick does not match event kind");

    // Only steering and acceleration setpoints can be clamped.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[16]) |->
            ((m_tuser[1:0] == EV_APPLIED) &&
             ((m_tuser[3:2] == CMD_STEER) || (m_tuser[3:2] == CMD_ACCEL))))
        else $error("clamp flag on a command that cannot be clamped");

    // A timeout carries a zero setpoint.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[1:0] == EV_TIMEOUT)) |-> (m_tdata[16:0] == 17'd0))
        else $error("timeout result carries a value");

    // The back end never takes a beat from an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

// File: bench/teleop_command_byte_parser_test.sv
`timescale 1ns / 1ps
// ============================================================================
// Teleop command byte parser testbench
// Streams serial bytes and ticks into the parser under several register
// settings and handshake pressure levels. A scoreboard predicts every result
// beat from the accepted input beats and compares the beats field by field.
// ============================================================================
module teleop_command_byte_parser_test;
    import tcbp_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 8;
    localparam int LIMIT_CYCLES    = 400000;
    // A beat passes through the queue and the output register, and the block
    // queues at most two beats, so this settle time is plenty to let a trailing
    // header or data byte work its way through before a register write.
    localparam int SETTLE_CYCLES   = 10;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int NUM_PHASES      = 8;

    // Where the parser stands between beats.
    typedef enum logic [2:0] {
        PH_HUNT     = 3'd0,
        PH_STEER_LO = 3'd1,
        PH_STEER_HI = 3'd2,
        PH_ACCEL_LO = 3'd3,
        PH_ACCEL_HI = 3'd4,
        PH_DIR      = 3'd5,
        PH_BRAKE    = 3'd6
    } parse_phase_t;

    // ------------------------------------------------------------------------
    // Scoreboard: a beat-level copy of the parser plus the queue of result
    // events it has predicted but not yet seen on the result channel.
    // ------------------------------------------------------------------------
    class command_predictor;
        logic [7:0]   header_code [4];  // indexed by command kind
        logic [15:0]  steering_limit;
        logic [15:0]  accel_limit;
        logic [15:0]  byte_wait_ticks;
        parse_phase_t phase;
        logic [7:0]   low_half;
        logic [15:0]  wait_count;
        tcbp_result_t expected_events[$];
        int           accepted_beats;   // every input beat taken by the block
        int           failures;

        function new();
            header_code[CMD_STEER] = RST_STEERING_CODE;
            header_code[CMD_ACCEL] = RST_ACCEL_CODE;
            header_code[CMD_DIR]   = RST_DIRECTION_CODE;
            header_code[CMD_BRAKE] = RST_BRAKE_CODE;
            steering_limit  = RST_STEERING_LIMIT;
            accel_limit     = RST_ACCEL_LIMIT;
            byte_wait_ticks = RST_BYTE_WAIT_TICKS;
            phase           = PH_HUNT;
            low_half        = '0;
            wait_count      = '0;
            accepted_beats  = 0;
            failures        = 0;
        endfunction

        function void set_register(logic [2:0] index, logic [15:0] value);
            case (index)
                CFG_STEERING_CODE:   header_code[CMD_STEER] = value[7:0];
                CFG_ACCEL_CODE:      header_code[CMD_ACCEL] = value[7:0];
                CFG_DIRECTION_CODE:  header_code[CMD_DIR]   = value[7:0];
                CFG_BRAKE_CODE:      header_code[CMD_BRAKE] = value[7:0];
                CFG_STEERING_LIMIT:  steering_limit  = value;
                CFG_ACCEL_LIMIT:     accel_limit     = value;
                CFG_BYTE_WAIT_TICKS: byte_wait_ticks = value;
                default: ;
            endcase
        endfunction

        function cmd_kind_t phase_command(parse_phase_t ph);
            case (ph)
                PH_STEER_LO, PH_STEER_HI: return CMD_STEER;
                PH_ACCEL_LO, PH_ACCEL_HI: return CMD_ACCEL;
                PH_DIR:                   return CMD_DIR;
                default:                  return CMD_BRAKE;
            endcase
        endfunction

        // Notes one accepted input beat and queues the event it causes, if any.
        function void take_beat(logic tick, logic [7:0] rx);
            tcbp_result_t ev;
            logic [16:0]  next_wait;
            logic [15:0]  value;
            logic [15:0]  limit;
            ev = '0;
            accepted_beats++;
            if (phase == PH_HUNT) begin
                // Ticks and unknown bytes are dropped; on a tie the lower
                // command kind takes the header.
                if (!tick) begin
                    if (rx == header_code[CMD_STEER])      phase = PH_STEER_LO;
                    else if (rx == header_code[CMD_ACCEL]) phase = PH_ACCEL_LO;
                    else if (rx == header_code[CMD_DIR])   phase = PH_DIR;
                    else if (rx == header_code[CMD_BRAKE]) phase = PH_BRAKE;
                    wait_count = '0;
                end
                return;
            end
            ev.command_kind = phase_command(phase);
            if (tick) begin
                next_wait = {1'b0, wait_count} + 17'd1;
                if (next_wait >= {1'b0, byte_wait_ticks}) begin
                    ev.event_kind = EV_TIMEOUT;
                    expected_events.push_back(ev);
                    phase      = PH_HUNT;
                    wait_count = '0;
                end else begin
                    wait_count = next_wait[15:0];
                end
                return;
            end
            wait_count = '0;
            case (phase)
                PH_STEER_LO: begin
                    low_half = rx;
                    phase    = PH_STEER_HI;
                end
                PH_ACCEL_LO: begin
                    low_half = rx;
                    phase    = PH_ACCEL_HI;
                end
                PH_STEER_HI, PH_ACCEL_HI: begin
                    value = {rx, low_half};
                    limit = (phase == PH_STEER_HI) ? steering_limit : accel_limit;
                    ev.event_kind    = EV_APPLIED;
                    ev.watchdog_kick = 1'b1;
                    if (value > limit) begin
                        value          = limit;
                        ev.was_clamped = 1'b1;
                    end
                    ev.setpoint_value = value;
                    expected_events.push_back(ev);
                    phase = PH_HUNT;
                end
                default: begin
                    // Direction and brake take a single flag byte.
                    ev.setpoint_value = {8'd0, rx};
                    if (rx <= 8'd1) begin
                        ev.event_kind    = EV_APPLIED;
                        ev.watchdog_kick = 1'b1;
                    end else begin
                        ev.event_kind = EV_REJECTED;
                    end
                    expected_events.push_back(ev);
                    phase = PH_HUNT;
                end
            endcase
        endfunction

        // Compares one accepted result beat with the oldest prediction.
        function void check_result(tcbp_result_t seen);
            tcbp_result_t want;
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected result beat: event %0d command %0d value %h",
                         $time, seen.event_kind, seen.command_kind, seen.setpoint_value);
                failures++;
                return;
            end
            want = expected_events.pop_front();
            if (seen.event_kind !== want.event_kind) begin
                $display("%0t: event_kind expected %0d actual %0d",
                         $time, want.event_kind, seen.event_kind);
                failures++;
            end
            if (seen.command_kind !== want.command_kind) begin
                $display("%0t: command_kind expected %0d actual %0d",
                         $time, want.command_kind, seen.command_kind);
                failures++;
            end
            if (seen.setpoint_value !== want.setpoint_value) begin
                $display("%0t: setpoint_value expected %h actual %h",
                         $time, want.setpoint_value, seen.setpoint_value);
                failures++;
            end
            if (seen.was_clamped !== want.was_clamped) begin
                $display("%0t: was_clamped expected %b actual %b",
                         $time, want.was_clamped, seen.was_clamped);
                failures++;
            end
            if (seen.watchdog_kick !== want.watchdog_kick) begin
                $display("%0t: watchdog_kick expected %b actual %b",
                         $time, want.watchdog_kick, seen.watchdog_kick);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block itself. Every input is known from time zero.
    // ------------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr  = '0;
    logic [15:0] cfg_wdata = '0;

    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;
    int          cycle_count        = 0;

    command_predictor predictor = new();
    tcbp_result_t     seen_event;

    always #(HALF_PERIOD) aclk = ~aclk;

    teleop_command_byte_parser DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [7:0] rx_byte
        .s_tuser   (s_tuser),     // [0] mode
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [15:0] setpoint_value, [16] was_clamped,
                                  // [17] watchdog_kick, [23:18] zero
        .m_tuser   (m_tuser),     // [1:0] event_kind, [3:2] command_kind
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Reassemble the result beat in the package layout.
    assign seen_event = {m_tuser[1:0], m_tuser[3:2], m_tdata[15:0], m_tdata[16], m_tdata[17]};

    // Both channels are sampled on the rising edge, where the testbench's own
    // falling-edge drives have long settled. The result is checked before the
    // input beat is noted, so a beat can never vouch for a result on its own
    // edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                predictor.check_result(seen_event);
            if (s_tvalid && s_tready)
                predictor.take_beat(s_tuser, s_tdata);
        end
    end

    // The receiver stalls at random, at a rate set by the current phase.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Hard stop if the run hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offers one beat after a random idle gap and holds it until accepted.
    // tvalid is only ever lowered at one falling edge and raised at a later
    // one, never both in the same time step.
    task automatic send_beat(input logic tick, input logic [7:0] rx);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= tick;
        s_tdata  <= rx;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops sending and waits until every predicted event has come out, then
    // gives any beat that causes no event time to leave the queue.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (predictor.expected_events.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [15:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= value;
        predictor.set_register(index, value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_setting(input logic [7:0] steer_code, input logic [7:0] accel_code,
                                 input logic [7:0] dir_code, input logic [7:0] brake_code,
                                 input logic [15:0] steer_lim, input logic [15:0] accel_lim,
                                 input logic [15:0] wait_ticks);
        write_register(CFG_STEERING_CODE, {8'd0, steer_code});
        write_register(CFG_ACCEL_CODE, {8'd0, accel_code});
        write_register(CFG_DIRECTION_CODE, {8'd0, dir_code});
        write_register(CFG_BRAKE_CODE, {8'd0, brake_code});
        write_register(CFG_STEERING_LIMIT, steer_lim);
        write_register(CFG_ACCEL_LIMIT, accel_lim);
        write_register(CFG_BYTE_WAIT_TICKS, wait_ticks);
    endtask

    // Now and then a few ticks fall between data bytes; with a short wait
    // setting these end the command in a timeout.
    task automatic tick_gap();
        if ($urandom_range(7) == 0)
            repeat ($urandom_range(1, 3)) send_beat(1'b1, 8'($urandom));
    endtask

    // One random stretch of traffic. Most of it is complete commands with
    // random payloads; the rest is stray bytes, idle ticks and commands
    // whose data never arrives.
    task automatic random_command();
        int          pick;
        int          kind;
        int          silence;
        logic [15:0] value;
        logic [15:0] limit;
        pick = $urandom_range(99);
        kind = $urandom_range(3);
        if (pick < 70) begin
            send_beat(1'b0, predictor.header_code[kind]);
            if (kind < 2) begin
                limit = (kind == 0) ? predictor.steering_limit : predictor.accel_limit;
                // Bias the payload toward the clamp boundary and the extremes.
                case ($urandom_range(5))
                    0:       value = 16'h0000;
                    1:       value = 16'hFFFF;
                    2:       value = limit;
                    3:       value = limit + 16'd1;
                    default: value = 16'($urandom);
                endcase
                tick_gap();
                send_beat(1'b0, value[7:0]);
                tick_gap();
                send_beat(1'b0, value[15:8]);
            end else begin
                tick_gap();
                if ($urandom_range(3) != 0)
                    send_beat(1'b0, 8'($urandom_range(1)));
                else
                    send_beat(1'b0, 8'($urandom));
            end
        end else if (pick < 80) begin
            send_beat(1'b0, 8'($urandom));
        end else if (pick < 88) begin
            repeat ($urandom_range(1, 4)) send_beat(1'b1, 8'($urandom));
        end else begin
            // Header followed by silence: run into the timeout when the wait
            // is short enough, otherwise leave the command hanging.
            send_beat(1'b0, predictor.header_code[kind]);
            silence = (predictor.byte_wait_ticks <= 16'd30) ?
                      int'(predictor.byte_wait_ticks) : $urandom_range(1, 30);
            repeat (silence) send_beat(1'b1, 8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed opening under the reset register values: {tick, byte}.
    // It covers ticks and stray bytes while hunting, every command kind,
    // the byte extremes, accepted and rejected flag bytes, and ticks that
    // fall between data bytes without running out the wait.
    // ------------------------------------------------------------------------
    localparam logic [8:0] OPENING [26] = '{
        9'h1A5, 9'h000, 9'h0FF,
        9'h001, 9'h034, 9'h012,
        9'h002, 9'h0FF, 9'h0FF,
        9'h003, 9'h000,
        9'h003, 9'h001,
        9'h004, 9'h001,
        9'h004, 9'h000,
        9'h003, 9'h002,
        9'h004, 9'h0FF,
        9'h001, 9'h15A, 9'h000, 9'h1C3, 9'h080
    };

    initial begin
        int target;
        bit paused;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (OPENING[i])
            send_beat(OPENING[i][8], OPENING[i][7:0]);
        settle();

        // Each phase picks an idling pattern and a register setting. The
        // fixed settings reach the extremes and the header tie-breaks; the
        // later ones are random with short waits so timeouts are frequent.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 59; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 59; end
                default: begin sender_idle_pct = 9; receiver_stall_pct = 9; end
            endcase
            case (p)
                0: ;  // stay at the reset values
                1: apply_setting(8'hFF, 8'h00, 8'h80, 8'h7F, 16'h0000, 16'hFFFF, 16'd1);
                2: apply_setting(8'h55, 8'h55, 8'h55, 8'h55, 16'h1234, 16'h8000, 16'd3);
                3: apply_setting(8'h20, 8'h10, 8'h10, 8'h10, 16'hFFFF, 16'h0000, 16'hFFFF);
                4: apply_setting(8'h01, 8'h02, 8'h09, 8'h09, 16'($urandom), 16'($urandom),
                                 16'd2);
                default: apply_setting(8'($urandom), 8'($urandom), 8'($urandom),
                                       8'($urandom), 16'($urandom), 16'($urandom),
                                       16'($urandom_range(1, 6)));
            endcase
            target = predictor.accepted_beats + ITEMS_PER_PHASE;
            paused = 1'b0;
            while (predictor.accepted_beats < target) begin
                random_command();
                // Halfway through, let the block run completely dry once.
                if (!paused && predictor.accepted_beats >= target - ITEMS_PER_PHASE / 2) begin
                    settle();
                    paused = 1'b1;
                end
            end
            settle();
        end

        if (predictor.failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
